@@ src/assert_macros.svh @@
// Shared assertion helpers for the frustum cull block.
// Each macro takes a label, a clock, an active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapped implication; the consequent may carry its own cycle delay.
`define AFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("assertion failed");

// Plain invariant, checked at every clock edge outside reset.
`define AFC_ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`endif

@@ src/afc_pkg.sv @@
// ----------------------------------------------------------------------------
// afc_pkg
// Shared widths, matrix types and reset values for the box frustum cull.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afc_pkg;

  // Fixed-point format of matrix entries and coordinates
  localparam int FracBits   = 16;
  localparam int CoordW     = 32;
  localparam int EntryW     = 32;
  localparam int PairW      = 2 * EntryW;

  // Exact arithmetic widths: product, partial sum, clip value, plane test
  localparam int ProdW      = 2 * EntryW;
  localparam int SumW       = ProdW + 1;
  localparam int ClipW      = ProdW + 2;
  localparam int TestW      = ProdW + 3;

  localparam int NumPairs   = 8;
  localparam int NumRows    = 4;
  localparam int NumEntries = NumRows * NumRows;
  localparam int NumAxes    = 3;
  localparam int NumCorners = 8;
  localparam int NumPlanes  = 6;
  localparam int IndexW     = 4;
  localparam int PairSelW   = $clog2(NumPairs);

  // Accept edge to result strobe, in cycles
  localparam int Latency    = 5;

  typedef logic [NumPairs-1:0][PairW-1:0]    pairs_t;
  typedef logic [NumEntries-1:0][EntryW-1:0] mat_t;
  typedef logic [NumAxes-1:0][1:0][CoordW-1:0] box_t;
  typedef logic [NumCorners-1:0][NumRows-1:0][ClipW-1:0] clip_arr_t;

  // Clip values of all eight corners with their valid bit
  typedef struct packed {
    logic      valid;
    clip_arr_t clip;
  } clip_bus_t;

  // Identity matrix: entries 0, 5, 10 and 15 equal one
  localparam logic [PairW-1:0] PairOneLo = PairW'(1) << FracBits;
  localparam logic [PairW-1:0] PairOneHi = PairOneLo << EntryW;
  localparam pairs_t PairsRst = '{PairOneHi, '0, PairOneLo, '0,
                                  '0, PairOneHi, '0, PairOneLo};

  // Split the register pairs into 16 entries, index = column*4 + row
  function automatic mat_t unpack_pairs(pairs_t pairs);
    mat_t m;
    for (int e = 0; e < NumEntries; e++) begin
      if ((e & 1) != 0) begin
        m[e] = pairs[e >> 1][PairW-1:EntryW];
      end else begin
        m[e] = pairs[e >> 1][EntryW-1:0];
      end
    end
    return m;
  endfunction

endpackage

@@ src/aabb_frustum_cull.sv @@
// ----------------------------------------------------------------------------
// aabb_frustum_cull - clip-space visibility test of one axis-aligned box
// done_o strobes after the transform, outside-flag and result registers.
// Throughput: one box per cycle; busy stays low, 24 multipliers in stage 1.
// Reset clears the valid pipeline and loads the identity; no receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_frustum_cull (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [afc_pkg::CoordW-1:0]  box_min_x_i,
  input  logic signed [afc_pkg::CoordW-1:0]  box_min_y_i,
  input  logic signed [afc_pkg::CoordW-1:0]  box_min_z_i,
  input  logic signed [afc_pkg::CoordW-1:0]  box_max_x_i,
  input  logic signed [afc_pkg::CoordW-1:0]  box_max_y_i,
  input  logic signed [afc_pkg::CoordW-1:0]  box_max_z_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [afc_pkg::IndexW-1:0]         cfg_index_i,
  input  logic [afc_pkg::PairW-1:0]          cfg_data_i,
  output logic                               done_o,
  output logic                               visible_o
);
  import afc_pkg::*;

  pairs_t    pairs_q;
  box_t      box;
  clip_bus_t clip_bus;
  logic [NumPlanes-1:0][NumCorners-1:0] out_d, out_q;
  logic      v4_q;
  logic      visible_d, visible_q, done_q;

  // Never stalls
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Matrix registers; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_q <= PairsRst;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < IndexW'(NumPairs))) begin
      pairs_q[cfg_index_i[PairSelW-1:0]] <= cfg_data_i;
    end
  end

  assign box[0][0] = box_min_x_i;
  assign box[0][1] = box_max_x_i;
  assign box[1][0] = box_min_y_i;
  assign box[1][1] = box_max_y_i;
  assign box[2][0] = box_min_z_i;
  assign box[2][1] = box_max_z_i;

  afc_xform u_xform (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start && !busy),
    .box_i    (box),
    .matrix_i (unpack_pairs(pairs_q)),
    .clip_o   (clip_bus)
  );

  // Stage 4: per corner and plane, outside flags (cv < -w, cv > w)
  always_comb begin
    logic [TestW-1:0] sum;
    logic [TestW-1:0] diff;
    for (int c = 0; c < NumCorners; c++) begin
      for (int r = 0; r < NumAxes; r++) begin
        sum  = TestW'($signed(clip_bus.clip[c][r])) +
               TestW'($signed(clip_bus.clip[c][NumAxes]));
        diff = TestW'($signed(clip_bus.clip[c][r])) -
               TestW'($signed(clip_bus.clip[c][NumAxes]));
        out_d[2*r][c]     = sum[TestW-1];
        out_d[2*r + 1][c] = !diff[TestW-1] && (diff != '0);
      end
    end
  end

  // Stage 5: invisible when one plane has all corners outside
  always_comb begin
    visible_d = 1'b1;
    for (int p = 0; p < NumPlanes; p++) begin
      if (&out_q[p]) begin
        visible_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    visible_q <= visible_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v4_q   <= clip_bus.valid;
      done_q <= v4_q;
    end
  end

  assign done_o    = done_q;
  assign visible_o = visible_q;

endmodule

@@ src/afc_xform.sv @@
// ----------------------------------------------------------------------------
// afc_xform
// Three-stage transform of the eight box corners into exact clip space.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afc_xform (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  afc_pkg::box_t      box_i,
  input  afc_pkg::mat_t      matrix_i,
  output afc_pkg::clip_bus_t clip_o
);
  import afc_pkg::*;

  // Per row, axis and min/max choice: one entry times one coordinate
  logic [NumRows-1:0][NumAxes-1:0][1:0][ProdW-1:0] prod_d, prod_q;
  // Per row: x+y terms for the four x/y choices, z+w terms for two z choices
  logic [NumRows-1:0][3:0][SumW-1:0] xy_d, xy_q;
  logic [NumRows-1:0][1:0][SumW-1:0] zw_d, zw_q;
  clip_arr_t clip_d, clip_q;
  logic      v1_q, v2_q, v3_q;

  // Stage 1: 24 signed multiplies
  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      for (int a = 0; a < NumAxes; a++) begin
        for (int s = 0; s < 2; s++) begin
          prod_d[r][a][s] = ProdW'($signed(matrix_i[a*NumRows + r]) *
                                   $signed(box_i[a][s]));
        end
      end
    end
  end

  // Stage 2: pair up products, add the scaled translation term
  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      for (int k = 0; k < 4; k++) begin
        xy_d[r][k] = SumW'($signed(prod_q[r][0][k & 1])) +
                     SumW'($signed(prod_q[r][1][(k >> 1) & 1]));
      end
      for (int s = 0; s < 2; s++) begin
        zw_d[r][s] = SumW'($signed(prod_q[r][2][s])) +
                     (SumW'($signed(matrix_i[NumAxes*NumRows + r])) <<< FracBits);
      end
    end
  end

  // Stage 3: full clip component per corner and row
  always_comb begin
    for (int c = 0; c < NumCorners; c++) begin
      for (int r = 0; r < NumRows; r++) begin
        clip_d[c][r] = ClipW'($signed(xy_q[r][c & 3])) +
                       ClipW'($signed(zw_q[r][(c >> 2) & 1]));
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    xy_q   <= xy_d;
    zw_q   <= zw_d;
    clip_q <= clip_d;
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign clip_o.valid = v3_q;
  assign clip_o.clip  = clip_q;

endmodule

@@ src/afc_checker.sv @@
// ----------------------------------------------------------------------------
// afc_checker
// Port-level checks on the frustum cull: fixed latency and clean results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module afc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic visible_o
);
  import afc_pkg::*;

  // Every start transfer yields exactly one strobe, a fixed time later
  `AFC_ASSERT_IMP(a_done_after_start, clk_i, rst_ni, start && !busy, ##Latency done_o)
  `AFC_ASSERT_IMP(a_no_spurious_done, clk_i, rst_ni, !(start && !busy), ##Latency !done_o)
  // A strobed result carries a known value
  `AFC_ASSERT_ALWAYS(a_result_known, clk_i, rst_ni, !done_o || !$isunknown(visible_o))

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (.*);

@@ dv/tb_aabb_frustum_cull.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aabb_frustum_cull
// Self-checking bench for the box frustum cull. A scoreboard class holds its
// own copy of the 4x4 matrix and predicts visibility with exact 128-bit clip
// math. Boxes are mostly scene-sized, some inverted, some raw 32-bit noise,
// under identity, extreme, camera-like and random matrices, with bursts and
// random idle gaps on the start side.
// ----------------------------------------------------------------------------

module tb_aabb_frustum_cull;

  import afc_pkg::*;

  localparam int ClkPeriod   = 20;
  localparam int RstCycles   = 4;
  localparam int NumSettings = 12;
  localparam int BoxesPerSet = 158;
  localparam int MaxGap      = 20;
  localparam int NumIndexes  = 1 << IndexW;
  localparam int One         = 1 << FracBits;

  // Plane slots in the outside mask
  localparam int PlaneLeft   = 0;
  localparam int PlaneRight  = 1;
  localparam int PlaneBottom = 2;
  localparam int PlaneTop    = 3;
  localparam int PlaneNear   = 4;
  localparam int PlaneFar    = 5;

  // Matrix settings that are not drawn at random
  localparam int SetIdentity = 0;
  localparam int SetAllMax   = 1;
  localparam int SetAllMin   = 2;
  localparam int SetAllZero  = 3;

  typedef logic signed [127:0] acc_t;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
  } box_item_t;

  // --------------------------------------------------------------------------
  // Visibility predictor and queue of expected flags
  // --------------------------------------------------------------------------
  class cull_scoreboard;
    logic [PairW-1:0] pairs [NumPairs];
    bit               exp_visible [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      culled;

    function new();
      logic [PairW-1:0] unit;
      unit = PairW'(One);
      foreach (pairs[i]) pairs[i] = '0;
      pairs[0] = unit;
      pairs[2] = unit << EntryW;
      pairs[5] = unit;
      pairs[7] = unit << EntryW;
      errors  = 0;
      checked = 0;
      culled  = 0;
    endfunction

    // Indexes past the last pair are dropped by the block
    function void write_reg(int unsigned idx, logic [PairW-1:0] data);
      if (idx < NumPairs) pairs[idx] = data;
    endfunction

    function logic signed [EntryW-1:0] entry(int e);
      logic [PairW-1:0] p;
      p = pairs[e >> 1];
      return (e % 2) ? p[PairW-1:EntryW] : p[EntryW-1:0];
    endfunction

    // One clip component, exact, with 2*FracBits fraction bits
    function acc_t row_clip(int r, logic signed [CoordW-1:0] x,
                            logic signed [CoordW-1:0] y,
                            logic signed [CoordW-1:0] z);
      return acc_t'(entry(r)) * acc_t'(x) + acc_t'(entry(4 + r)) * acc_t'(y)
           + acc_t'(entry(8 + r)) * acc_t'(z)
           + (acc_t'(entry(12 + r)) <<< FracBits);
    endfunction

    function bit predict_visible(box_item_t b);
      acc_t                     clip [NumRows];
      logic signed [CoordW-1:0] x, y, z;
      bit [NumPlanes-1:0]       all_out;
      bit [NumPlanes-1:0]       out_now;
      all_out = '1;
      for (int k = 0; k < NumCorners; k++) begin
        x = k[0] ? b.max_x : b.min_x;
        y = k[1] ? b.max_y : b.min_y;
        z = k[2] ? b.max_z : b.min_z;
        for (int r = 0; r < NumRows; r++) clip[r] = row_clip(r, x, y, z);
        out_now[PlaneLeft]   = (clip[0] + clip[3]) < 0;
        out_now[PlaneRight]  = (clip[0] - clip[3]) > 0;
        out_now[PlaneBottom] = (clip[1] + clip[3]) < 0;
        out_now[PlaneTop]    = (clip[1] - clip[3]) > 0;
        out_now[PlaneNear]   = (clip[2] + clip[3]) < 0;
        out_now[PlaneFar]    = (clip[2] - clip[3]) > 0;
        all_out &= out_now;
      end
      return all_out == '0;
    endfunction

    function void note_box(box_item_t b);
      exp_visible.push_back(predict_visible(b));
    endfunction

    function void check_result(logic vis);
      bit want;
      if (exp_visible.size() == 0) begin
        $error("visible: result with nothing expected, actual %0b", vis);
        errors++;
        return;
      end
      want = exp_visible.pop_front();
      checked++;
      if (!want) culled++;
      if (vis !== want) begin
        $error("visible mismatch: expected %0b, actual %0b", want, vis);
        errors++;
      end
    endfunction

    function int pending();
      return exp_visible.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  box_item_t        box_drv     = '0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [IndexW-1:0] cfg_index_i = '0;
  logic [PairW-1:0] cfg_data_i  = '0;
  logic             done_o;
  logic             visible_o;

  cull_scoreboard   sb = new();

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  aabb_frustum_cull dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .box_min_x_i (box_drv.min_x),
    .box_min_y_i (box_drv.min_y),
    .box_min_z_i (box_drv.min_z),
    .box_max_x_i (box_drv.max_x),
    .box_max_y_i (box_drv.max_y),
    .box_max_z_i (box_drv.max_z),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .visible_o   (visible_o)
  );

  // Watch both sides at the edge: box transfers feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_box(box_drv);
      if (done_o) sb.check_result(visible_o);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int signed_rand(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic box_item_t make_box(int x0, int y0, int z0, int x1, int y1, int z1);
    box_item_t b;
    b.min_x = x0; b.min_y = y0; b.min_z = z0;
    b.max_x = x1; b.max_y = y1; b.max_z = z1;
    return b;
  endfunction

  // Mostly scene-sized boxes, some inverted, some raw bit noise
  function automatic box_item_t random_box();
    int r, span, c, h, t;
    int lo [3];
    int hi [3];
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return make_box($urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom());
    end
    span = 1 << $urandom_range(14, 22);
    for (int a = 0; a < 3; a++) begin
      c = signed_rand(span);
      h = $urandom_range(0, span / 2);
      lo[a] = c - h;
      hi[a] = c + h;
      if (r < 25 && $urandom_range(0, 1) == 1) begin
        t = lo[a]; lo[a] = hi[a]; hi[a] = t;
      end
    end
    return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  // Perspective-like projection with a small random tilt and offset
  function automatic mat_t camera_matrix();
    mat_t m;
    m     = '0;
    m[0]  = $urandom_range(One / 2, 3 * One);
    m[5]  = $urandom_range(One / 2, 3 * One);
    m[1]  = signed_rand(One / 10);
    m[4]  = signed_rand(One / 10);
    m[8]  = signed_rand(One / 4);
    m[9]  = signed_rand(One / 4);
    m[10] = -int'($urandom_range(One, One + One / 4));
    m[11] = -One;
    m[12] = signed_rand(2 * One);
    m[13] = signed_rand(2 * One);
    m[14] = -int'($urandom_range(One / 10, 10 * One));
    return m;
  endfunction

  // Box transfer; start stays high when the next box follows at once
  task automatic send_box(box_item_t b, int idle_pct);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct && gap < MaxGap) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    box_drv <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Register transfer; caller lowers valid after the last one
  task automatic write_pair(int unsigned idx, logic [PairW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= IndexW'(idx);
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Let every expected flag come back, then let the pipe settle
  task automatic drain_pipe();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  // Load a matrix setting; unknown indexes are mixed in and must be ignored
  task automatic load_setting(int s);
    mat_t m;
    case (s)
      SetAllMax:  for (int e = 0; e < NumEntries; e++) m[e] = 32'h7FFF_FFFF;
      SetAllMin:  for (int e = 0; e < NumEntries; e++) m[e] = 32'h8000_0000;
      SetAllZero: m = '0;
      default: begin
        if (s % 3 == 0) begin
          for (int e = 0; e < NumEntries; e++) m[e] = $urandom();
        end else begin
          m = camera_matrix();
        end
      end
    endcase
    for (int i = 0; i < NumPairs; i++) write_pair(i, {m[2 * i + 1], m[2 * i]});
    write_pair($urandom_range(NumPairs, NumIndexes - 1), {$urandom(), $urandom()});
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int        idle_tbl [4];
    box_item_t directed [$];
    int        boxes;
    idle_tbl = '{0, 57, 0, 30};
    boxes    = 0;

    repeat (RstCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unknown indexes right after reset must leave the identity in place
    for (int i = NumPairs; i < NumIndexes; i++) write_pair(i, {$urandom(), $urandom()});
    cfg_valid_i <= 1'b0;

    // Directed boxes against the identity: one plane at a time, edges, extremes
    directed.push_back(make_box(0, 0, 0, 0, 0, 0));
    directed.push_back(make_box(-One, -One, -One, One, One, One));
    directed.push_back(make_box(2 * One, -One / 2, -One / 2, 3 * One, One / 2, One / 2));
    directed.push_back(make_box(-3 * One, -One / 2, -One / 2, -2 * One, One / 2, One / 2));
    directed.push_back(make_box(-One / 2, -3 * One, -One / 2, One / 2, -2 * One, One / 2));
    directed.push_back(make_box(-One / 2, 2 * One, -One / 2, One / 2, 3 * One, One / 2));
    directed.push_back(make_box(-One / 2, -One / 2, -3 * One, One / 2, One / 2, -2 * One));
    directed.push_back(make_box(-One / 2, -One / 2, 2 * One, One / 2, One / 2, 3 * One));
    // corner exactly on the right plane, then one step past it
    directed.push_back(make_box(One, 0, 0, One, 0, 0));
    directed.push_back(make_box(One + 1, 0, 0, One + 1, 0, 0));
    directed.push_back(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    directed.push_back(make_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    directed.push_back(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    directed.push_back(make_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    // inverted boxes: fully outside, and straddling the view
    directed.push_back(make_box(3 * One, 0, 0, 2 * One, 0, 0));
    directed.push_back(make_box(One, One, One, -One, -One, -One));
    foreach (directed[i]) begin
      send_box(directed[i], 0);
      boxes++;
    end

    // Random boxes across matrix settings and idle patterns
    for (int s = 0; s < NumSettings; s++) begin
      if (s != SetIdentity) begin
        start <= 1'b0;
        drain_pipe();
        load_setting(s);
      end
      for (int n = 0; n < BoxesPerSet; n++) begin
        send_box(random_box(), idle_tbl[s % 4]);
        boxes++;
      end
    end
    start <= 1'b0;
    drain_pipe();

    $display("Sent %0d boxes over %0d matrix settings; %0d checked, %0d culled.",
             boxes, NumSettings, sb.checked, sb.culled);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/afc_pkg.sv
src/afc_xform.sv
src/aabb_frustum_cull.sv
src/afc_checker.sv
dv/tb_aabb_frustum_cull.sv
